// ===== design/attention_state_warning_tracker_assert.svh =====
// Assertion macros shared by the tracker RTL.
`ifndef ATTENTION_STATE_WARNING_TRACKER_ASSERT_SVH
`define ATTENTION_STATE_WARNING_TRACKER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define ASWT_CHECK(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define ASWT_CHECK_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/aswt_pkg.sv =====
// Shared types, codes and constants of the attention state warning tracker.
package aswt_pkg;

    // Window depth default
    localparam int WINDOW_LEN_DEF = 8;

    // Attention classes
    localparam logic [1:0] ST_ATTENTIVE  = 2'd0;
    localparam logic [1:0] ST_DISTRACTED = 2'd1;
    localparam logic [1:0] ST_DROWSY     = 2'd2;

    // Warning levels
    localparam logic [1:0] LVL_NONE = 2'd0;
    localparam logic [1:0] LVL_ONE  = 2'd1;
    localparam logic [1:0] LVL_TWO  = 2'd2;

    // Warning timer steps, ms
    localparam logic [31:0] WARN1_AFTER_MS  = 32'd5000;
    localparam logic [31:0] WARN2_AFTER_MS  = 32'd20000;
    localparam logic [31:0] DECAY1_AFTER_MS = 32'd16000;
    localparam logic [31:0] DECAY2_AFTER_MS = 32'd25000;

    // Alpha of one in Q1.16
    localparam logic [16:0] ALPHA_ONE = 17'h10000;

    // Configuration register reset values
    localparam logic [15:0]        EAR_THR_RST    = 16'd1024;
    localparam logic signed [15:0] YAW_THR_RST    = 16'sd2000;
    localparam logic [15:0]        EAR_FRAMES_RST = 16'd15;
    localparam logic [15:0]        LONG_FRAMES_RST = 16'd60;
    localparam logic [15:0]        YAW_FRAMES_RST = 16'd15;
    localparam logic [15:0]        NOFACE_FRAMES_RST = 16'd30;
    localparam logic [16:0]        ALPHA_RST      = 17'd19661;
    localparam logic [31:0]        LOCK_MS_RST    = 32'd5000;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_EAR_THR      = 3'd0,
        REG_YAW_THR      = 3'd1,
        REG_EAR_FRAMES   = 3'd2,
        REG_LONG_FRAMES  = 3'd3,
        REG_YAW_FRAMES   = 3'd4,
        REG_NOFACE_FRAMES = 3'd5,
        REG_ALPHA        = 3'd6,
        REG_LOCK_MS      = 3'd7
    } t_cfg_idx;

    // Top level sequencer
    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_MED,
        S_MUL,
        S_AVG,
        S_COUNT,
        S_WARN,
        S_ACT
    } t_aswt_state;

    // Median unit sequencer
    typedef enum logic [2:0] {
        M_IDLE,
        M_CAND,
        M_LOAD,
        M_SCAN,
        M_CHECK
    } t_med_state;

    // Median unit response
    typedef struct packed {
        logic               done;
        logic signed [15:0] median;
    } t_med_rsp;

    // Saturating 16-bit increment
    function automatic logic [15:0] sat_inc16(input logic [15:0] c);
        return (c == 16'hFFFF) ? c : c + 16'd1;
    endfunction

endpackage

// ===== design/aswt_median.sv =====
// Yaw window memory with a serial rank search for the median.
module aswt_median import aswt_pkg::*; #(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [15:0] i_yaw,
    output t_med_rsp           o_rsp
);

    localparam int PW = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int FW = $clog2(WINDOW_LEN + 1);
    localparam logic [FW-1:0] FILL_MAX = FW'(WINDOW_LEN);

    t_med_state r_state, n_state;

    logic signed [15:0] r_mem [WINDOW_LEN];
    logic signed [15:0] r_rd_data;
    logic signed [15:0] r_cand;
    logic [PW-1:0]      r_wr_ptr;
    logic [PW-1:0]      r_cand_idx;
    logic [FW-1:0]      r_fill;
    logic [FW-1:0]      r_scan;
    logic [FW-1:0]      r_lt;
    logic [FW-1:0]      r_le;
    logic [FW-1:0]      k_mid;

    logic          rd_en;
    logic [PW-1:0] rd_addr;
    logic          found;

    assign k_mid = r_fill >> 1;
    // candidate is the median when rank window covers the middle index
    assign found = (r_lt <= k_mid) && (k_mid < r_le);

    // sequencer
    always_comb begin
        n_state = r_state;
        rd_en   = 1'b0;
        rd_addr = r_cand_idx;
        unique case (r_state)
            M_IDLE: begin
                if (i_start) n_state = M_CAND;
            end
            M_CAND: begin
                rd_en   = 1'b1;
                rd_addr = r_cand_idx;
                n_state = M_LOAD;
            end
            M_LOAD: begin
                rd_en   = 1'b1;
                rd_addr = '0;
                n_state = M_SCAN;
            end
            M_SCAN: begin
                if (r_scan == r_fill) begin
                    n_state = M_CHECK;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_scan[PW-1:0];
                end
            end
            M_CHECK: begin
                n_state = found ? M_IDLE : M_CAND;
            end
            default: n_state = M_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= M_IDLE;
        else          r_state <= n_state;
    end

    // window memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (r_state == M_IDLE && i_start) r_mem[r_wr_ptr] <= i_yaw;
        if (rd_en) r_rd_data <= r_mem[rd_addr];
    end

    // fill level and circular write pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_wr_ptr <= '0;
        end else if (r_state == M_IDLE && i_start) begin
            if (r_fill != FILL_MAX) r_fill <= r_fill + FW'(1);
            if (r_wr_ptr == PW'(WINDOW_LEN - 1)) r_wr_ptr <= '0;
            else                                 r_wr_ptr <= r_wr_ptr + PW'(1);
        end
    end

    // rank counting over the window
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            M_IDLE: begin
                r_cand_idx <= '0;
            end
            M_LOAD: begin
                r_cand <= r_rd_data;
                r_scan <= FW'(1);
                r_lt   <= '0;
                r_le   <= '0;
            end
            M_SCAN: begin
                r_lt <= r_lt + FW'(r_rd_data < r_cand);
                r_le <= r_le + FW'(r_rd_data <= r_cand);
                if (r_scan != r_fill) r_scan <= r_scan + FW'(1);
            end
            M_CHECK: begin
                if (!found) r_cand_idx <= r_cand_idx + PW'(1);
            end
            default: ;
        endcase
    end

    assign o_rsp.done   = (r_state == M_CHECK) && found;
    assign o_rsp.median = r_cand;

`include "attention_state_warning_tracker_assert.svh"

    `ASWT_CHECK(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill <= FILL_MAX, "fill above window length")
    `ASWT_CHECK(a_ptr_tracks_fill, i_clk, i_rst_n, r_fill != FILL_MAX, FW'(r_wr_ptr) == r_fill, "write pointer off fill level")
    `ASWT_CHECK_NEXT(a_done_pulse, i_clk, i_rst_n, o_rsp.done, !o_rsp.done, "median done held")

endmodule

// ===== design/attention_state_warning_tracker.sv =====
// Accept to result valid: an action beat passes S_START, S_ACT; a no-face frame
// S_START, S_COUNT, S_WARN; a landmark frame S_START, S_MED, S_MUL, S_AVG, S_COUNT,
// S_WARN, S_MED being the serial rank search: each candidate in turn is read from
// the window memory, then ranked through its single read port. Throughput: one item
// at a time; the next beat is taken the cycle after the result is registered. Reset
// (synchronous, active low) clears counters, timers, warnings; loads config defaults.
module attention_state_warning_tracker import aswt_pkg::*; #(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration write port
    input  logic               i_cfg_wr_en,
    input  logic [2:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    // input beats
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_action,
    input  logic               i_face_found,
    input  logic [15:0]        i_eye_ratio,
    input  logic signed [15:0] i_raw_yaw,
    input  logic [31:0]        i_now_ms,
    // result beats
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [1:0]         o_attention_state,
    output logic [1:0]         o_warning_level,
    output logic               o_warning_raised,
    output logic signed [15:0] o_smoothed_yaw
);

    t_aswt_state r_state, n_state;

    // configuration registers
    logic [15:0]        r_ear_thr;
    logic signed [15:0] r_yaw_thr;
    logic [15:0]        r_ear_frames;
    logic [15:0]        r_long_frames;
    logic [15:0]        r_yaw_frames;
    logic [15:0]        r_noface_frames;
    logic [16:0]        r_alpha;
    logic [31:0]        r_lock_ms;

    // latched input beat
    logic               r_act;
    logic               r_face;
    logic [15:0]        r_ear;
    logic signed [15:0] r_yaw;
    logic [31:0]        r_now;

    // tracker state
    logic signed [15:0] r_med;
    logic signed [34:0] r_prod;
    logic signed [15:0] r_avg;
    logic [15:0]        r_noface_cnt;
    logic [15:0]        r_closed_cnt;
    logic [15:0]        r_away_cnt;
    logic [1:0]         r_level;
    logic [1:0]         r_prior;
    logic [31:0]        r_since;
    logic [31:0]        r_first;

    // output register
    logic               r_out_valid;
    logic [1:0]         r_out_state;
    logic [1:0]         r_out_level;
    logic               r_out_raised;
    logic signed [15:0] r_out_yaw;

    logic     in_fire;
    logic     out_free;
    logic     med_start;
    t_med_rsp med_rsp;

    logic [16:0]        alpha_c;
    logic signed [16:0] yaw_diff;
    logic signed [34:0] prod_rnd;
    logic signed [34:0] prod_shr;

    logic               cnt_closed;
    logic               cnt_away;
    logic [15:0]        n_noface_cnt;

    logic [1:0]  w_curr;
    logic [1:0]  w_shown;
    logic [31:0] w_elapsed;
    logic [31:0] w_lock_age;
    logic [1:0]  n_level;
    logic        w_raised;
    logic [31:0] n_first;
    logic [31:0] n_since;
    logic [1:0]  n_prior;

    assign in_fire   = i_in_valid && o_in_ready;
    assign out_free  = !r_out_valid || i_out_ready;
    assign med_start = (r_state == S_START) && !r_act && r_face;

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_START;
            S_START: begin
                priority if (r_act) n_state = S_ACT;
                else if (r_face)    n_state = S_MED;
                else                n_state = S_COUNT;
            end
            S_MED:   if (med_rsp.done) n_state = S_MUL;
            S_MUL:   n_state = S_AVG;
            S_AVG:   n_state = S_COUNT;
            S_COUNT: n_state = S_WARN;
            S_WARN:  if (out_free) n_state = S_IDLE;
            S_ACT:   if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    assign o_in_ready = (r_state == S_IDLE);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ear_thr       <= EAR_THR_RST;
            r_yaw_thr       <= YAW_THR_RST;
            r_ear_frames    <= EAR_FRAMES_RST;
            r_long_frames   <= LONG_FRAMES_RST;
            r_yaw_frames    <= YAW_FRAMES_RST;
            r_noface_frames <= NOFACE_FRAMES_RST;
            r_alpha         <= ALPHA_RST;
            r_lock_ms       <= LOCK_MS_RST;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                REG_EAR_THR:       r_ear_thr       <= i_cfg_data[15:0];
                REG_YAW_THR:       r_yaw_thr       <= i_cfg_data[15:0];
                REG_EAR_FRAMES:    r_ear_frames    <= i_cfg_data[15:0];
                REG_LONG_FRAMES:   r_long_frames   <= i_cfg_data[15:0];
                REG_YAW_FRAMES:    r_yaw_frames    <= i_cfg_data[15:0];
                REG_NOFACE_FRAMES: r_noface_frames <= i_cfg_data[15:0];
                REG_ALPHA:         r_alpha         <= i_cfg_data[16:0];
                REG_LOCK_MS:       r_lock_ms       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input beat capture; raw yaw stays with the beat until the median unit takes it
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_act  <= i_action;
            r_face <= i_face_found;
            r_ear  <= i_eye_ratio;
            r_yaw  <= i_raw_yaw;
            r_now  <= i_now_ms;
        end
    end

    // window median
    aswt_median #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_median (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (med_start),
        .i_yaw   (r_yaw),
        .o_rsp   (med_rsp)
    );

    // exponential average: avg + floor((alpha*(med-avg) + half) / 2^16)
    assign alpha_c  = r_alpha[16] ? ALPHA_ONE : r_alpha;
    assign yaw_diff = {r_med[15], r_med} - {r_avg[15], r_avg};
    assign prod_rnd = r_prod + 35'sd32768;
    assign prod_shr = prod_rnd >>> 16;

    always_ff @(posedge i_clk) begin
        if (r_state == S_MED && med_rsp.done) r_med <= med_rsp.median;
        if (r_state == S_MUL) r_prod <= $signed({1'b0, alpha_c}) * yaw_diff;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)              r_avg <= '0;
        else if (r_state == S_AVG) r_avg <= r_avg + prod_shr[15:0];
    end

    // frame counters
    assign n_noface_cnt = r_face ? 16'd0 : sat_inc16(r_noface_cnt);
    assign cnt_closed   = r_face && (r_ear < r_ear_thr);
    assign cnt_away     = r_face ? (r_avg > r_yaw_thr) : (n_noface_cnt >= r_noface_frames);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_noface_cnt <= '0;
            r_closed_cnt <= '0;
            r_away_cnt   <= '0;
        end else if (r_state == S_COUNT) begin
            r_noface_cnt <= n_noface_cnt;
            r_closed_cnt <= cnt_closed ? sat_inc16(r_closed_cnt) : 16'd0;
            r_away_cnt   <= cnt_away ? sat_inc16(r_away_cnt) : 16'd0;
        end
    end

    // classification and warning timer
    always_comb begin
        w_curr = ST_ATTENTIVE;
        if (r_away_cnt >= r_yaw_frames || r_closed_cnt >= r_ear_frames) w_curr = ST_DISTRACTED;
        if (r_closed_cnt >= r_long_frames) w_curr = ST_DROWSY;

        w_elapsed = r_now - r_since;
        n_level   = r_level;
        w_raised  = 1'b0;
        n_first   = r_first;
        n_since   = r_since;
        n_prior   = r_prior;

        if (w_curr == r_prior) begin
            if (w_curr == ST_DISTRACTED) begin
                priority if (r_level == LVL_NONE && w_elapsed >= WARN1_AFTER_MS) begin
                    n_level  = LVL_ONE;
                    w_raised = 1'b1;
                    n_first  = r_now;
                end else if (r_level == LVL_ONE && w_elapsed >= WARN2_AFTER_MS) begin
                    n_level  = LVL_TWO;
                    w_raised = 1'b1;
                end
            end else begin
                if (r_level == LVL_ONE && w_elapsed >= DECAY1_AFTER_MS) n_level = LVL_NONE;
                if (r_level == LVL_TWO && w_elapsed >= DECAY2_AFTER_MS) n_level = LVL_NONE;
            end
        end else begin
            n_since = r_now;
            n_prior = w_curr;
        end

        // hold distracted for a while after the first warning
        w_lock_age = r_now - n_first;
        w_shown    = w_curr;
        if (n_level == LVL_ONE && w_lock_age < r_lock_ms) w_shown = ST_DISTRACTED;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= LVL_NONE;
            r_prior <= ST_ATTENTIVE;
            r_since <= '0;
            r_first <= '0;
        end else if (r_state == S_WARN && out_free) begin
            r_level <= n_level;
            r_prior <= n_prior;
            r_since <= n_since;
            r_first <= n_first;
        end else if (r_state == S_ACT && out_free) begin
            r_level <= LVL_NONE;
            r_since <= r_now;
            r_first <= r_now;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_WARN || r_state == S_ACT) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_WARN && out_free) begin
            r_out_state  <= w_shown;
            r_out_level  <= n_level;
            r_out_raised <= w_raised;
            r_out_yaw    <= r_face ? r_avg : 16'sd0;
        end else if (r_state == S_ACT && out_free) begin
            r_out_state  <= ST_ATTENTIVE;
            r_out_level  <= LVL_NONE;
            r_out_raised <= 1'b0;
            r_out_yaw    <= 16'sd0;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_attention_state = r_out_state;
    assign o_warning_level   = r_out_level;
    assign o_warning_raised  = r_out_raised;
    assign o_smoothed_yaw    = r_out_yaw;

`include "attention_state_warning_tracker_assert.svh"

    `ASWT_CHECK(a_raise_level, i_clk, i_rst_n, o_out_valid && o_warning_raised, o_warning_level != LVL_NONE, "raised beat at level none")
    `ASWT_CHECK(a_state_code, i_clk, i_rst_n, o_out_valid, o_attention_state == ST_ATTENTIVE || o_attention_state == ST_DISTRACTED || o_attention_state == ST_DROWSY, "bad attention class")
    `ASWT_CHECK(a_med_wait, i_clk, i_rst_n, med_rsp.done, r_state == S_MED, "median done outside wait")

endmodule
